### hw/rtl/bole_pkg.sv
// ----------------------------------------------------------------------------
// Bounded ordered list engine package
// Shared widths, operation and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned LEN_W_DEF       = $clog2(CAPACITY_DEF + 1);

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_HEAD    = 3'd0,
    OP_PUSH_TAIL    = 3'd1,
    OP_INSERT_AT    = 3'd2,
    OP_POP_HEAD     = 3'd3,
    OP_POP_TAIL     = 3'd4,
    OP_REMOVE_VALUE = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Control word that the sequencer hands to every cell of the chain.
  typedef struct packed {
    logic capture;      // register the key comparison
    logic load;         // write the new element into this cell
    logic take_left;    // take the left neighbor's element
    logic shift_all;    // close the gap at the head
    logic shift_found;  // close the gap at the first match
    logic occupied;     // cell holds a live element
    logic below_last;   // a live element sits to the right
    logic pick_fixed;   // this cell is the head or tail being popped
    logic search;       // remove-by-value is executing
  } cell_ctrl_t;

endpackage

### hw/rtl/bole_if.sv
// ----------------------------------------------------------------------------
// Bounded ordered list engine channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bole_req_if;
  logic                                valid;
  logic                                ready;
  logic [bole_pkg::OPCODE_W-1:0]       opcode;
  logic signed [bole_pkg::DATA_W-1:0]  value;
  logic [bole_pkg::POS_W-1:0]          position;

  modport source (output valid, opcode, value, position, input ready);
  modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface bole_rsp_if #(
  parameter int unsigned LEN_W = bole_pkg::LEN_W_DEF
);
  logic                                valid;
  logic                                ready;
  logic signed [bole_pkg::DATA_W-1:0]  removed_value;
  logic [bole_pkg::STATUS_W-1:0]       status;
  logic [LEN_W-1:0]                    length;

  modport source (output valid, removed_value, status, length, input ready);
  modport sink   (input valid, removed_value, status, length, output ready);
endinterface

### hw/rtl/bounded_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// Bounded ordered list engine
// Ordered deque of up to CAPACITY signed words held in a chain of cells.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake    | Payload
//  req_i   | in  | valid/ready  | opcode, value, position
//  rsp_o   | out | valid/ready  | removed_value, status, length
//
// A transaction has an accept step and an execute step: the accept cycle
// registers the request and every cell's key comparison, and the execute
// step resolves the first match along the cell chain and shifts all cells
// at once, which needs the response register free or drained that cycle.
// Reset clears the length and the handshake state; cell contents are unset.
// A new request is taken as soon as the previous one is in the response
// register, even while that response is still waiting.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine #(
  parameter int unsigned CAPACITY    = bole_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = bole_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bole_req_if.sink    req_i,
  bole_rsp_if.source  rsp_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > bole_pkg::POS_W) ? CW : bole_pkg::POS_W;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                     state_q;
  bole_pkg::op_e              op_q;
  logic [bole_pkg::POS_W-1:0] pos_q;
  logic [VALUE_WIDTH-1:0]     key_q;
  logic [CW-1:0]              count_q, count_d;

  logic                             out_valid_q;
  logic [bole_pkg::DATA_W-1:0]      out_removed_q, out_removed_d;
  bole_pkg::status_e                out_status_q, out_status_d;
  logic [CW-1:0]                    out_len_q;

  logic                   accept;
  logic                   exec_fire;
  logic [63:0]            val_ext;
  logic [VALUE_WIDTH-1:0] key_d;
  logic [VALUE_WIDTH-1:0] key_bus;
  logic [63:0]            rem_ext;

  logic          is_ins, full, empty;
  logic          ins_ok, pop_ok, srch, rem_ok;
  logic [CW-1:0] idx;
  logic [XW-1:0] pos_m1, count_x;

  logic                   found_w [CAPACITY+1];
  logic [VALUE_WIDTH-1:0] pick_w  [CAPACITY+1];
  logic [VALUE_WIDTH-1:0] val_w   [CAPACITY];

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid & req_i.ready;
  assign exec_fire   = (state_q == S_EXEC) & (~out_valid_q | rsp_o.ready);

  // Value is taken as a 32-bit signed word and kept at VALUE_WIDTH bits.
  assign val_ext = 64'($signed(req_i.value));
  assign key_d   = val_ext[VALUE_WIDTH-1:0];
  assign key_bus = accept ? key_d : key_q;

  // Operation decode and insert index.
  always_comb begin
    is_ins  = (op_q == bole_pkg::OP_PUSH_HEAD) || (op_q == bole_pkg::OP_PUSH_TAIL) ||
              (op_q == bole_pkg::OP_INSERT_AT);
    full    = (count_q == CW'(CAPACITY));
    empty   = (count_q == '0);
    ins_ok  = exec_fire & is_ins & ~full;
    pop_ok  = exec_fire & ~empty &
              ((op_q == bole_pkg::OP_POP_HEAD) || (op_q == bole_pkg::OP_POP_TAIL));
    srch    = exec_fire & ~empty & (op_q == bole_pkg::OP_REMOVE_VALUE);
    rem_ok  = srch & found_w[CAPACITY];
    count_x = XW'(count_q);
    pos_m1  = XW'(pos_q) - XW'(1);
    unique case (op_q)
      bole_pkg::OP_PUSH_HEAD: idx = '0;
      bole_pkg::OP_INSERT_AT: begin
        if (pos_q <= bole_pkg::POS_W'(1)) begin
          idx = '0;
        end else if (pos_m1 > count_x) begin
          idx = count_q;
        end else begin
          idx = CW'(pos_m1);
        end
      end
      default: idx = count_q;
    endcase
  end

  assign found_w[0] = 1'b0;
  assign pick_w[0]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX  = CW'(i);
    localparam logic [CW-1:0] IDX1 = CW'(i + 1);
    bole_pkg::cell_ctrl_t   ctrl;
    logic [VALUE_WIDTH-1:0] left;
    logic [VALUE_WIDTH-1:0] right;

    always_comb begin
      ctrl.capture     = accept;
      ctrl.load        = ins_ok & (idx == IDX);
      ctrl.take_left   = ins_ok & (IDX > idx) & (IDX <= count_q);
      ctrl.shift_all   = pop_ok & (op_q == bole_pkg::OP_POP_HEAD);
      ctrl.shift_found = srch;
      ctrl.occupied    = (IDX < count_q);
      ctrl.below_last  = (IDX1 < count_q);
      ctrl.pick_fixed  = pop_ok &
                         (((op_q == bole_pkg::OP_POP_HEAD) && (i == 0)) ||
                          ((op_q == bole_pkg::OP_POP_TAIL) && (IDX1 == count_q)));
      ctrl.search      = srch;
    end

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = val_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = val_w[i+1];
    end

    bole_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .key_i   (key_bus),
      .left_i  (left),
      .right_i (right),
      .found_i (found_w[i]),
      .pick_i  (pick_w[i]),
      .value_o (val_w[i]),
      .found_o (found_w[i+1]),
      .pick_o  (pick_w[i+1])
    );
  end

  assign rem_ext = 64'($signed(pick_w[CAPACITY]));

  always_comb begin
    out_removed_d = rem_ext[bole_pkg::DATA_W-1:0];
    count_d       = count_q;
    if (ins_ok) begin
      count_d = count_q + CW'(1);
    end else if (pop_ok | rem_ok) begin
      count_d = count_q - CW'(1);
    end
    unique case (op_q)
      bole_pkg::OP_PUSH_HEAD,
      bole_pkg::OP_PUSH_TAIL,
      bole_pkg::OP_INSERT_AT:
        out_status_d = full ? bole_pkg::ST_FULL : bole_pkg::ST_OK;
      bole_pkg::OP_POP_HEAD,
      bole_pkg::OP_POP_TAIL:
        out_status_d = empty ? bole_pkg::ST_EMPTY : bole_pkg::ST_OK;
      bole_pkg::OP_REMOVE_VALUE: begin
        if (empty) begin
          out_status_d = bole_pkg::ST_EMPTY;
        end else if (!found_w[CAPACITY]) begin
          out_status_d = bole_pkg::ST_NOT_FOUND;
        end else begin
          out_status_d = bole_pkg::ST_OK;
        end
      end
      default: out_status_d = bole_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      op_q          <= bole_pkg::OP_PUSH_HEAD;
      pos_q         <= '0;
      key_q         <= '0;
      out_removed_q <= '0;
      out_status_q  <= bole_pkg::ST_OK;
      out_len_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q    <= bole_pkg::op_e'(req_i.opcode);
            pos_q   <= req_i.position;
            key_q   <= key_d;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (exec_fire) begin
        count_q       <= count_d;
        out_valid_q   <= 1'b1;
        out_removed_q <= out_removed_d;
        out_status_q  <= out_status_d;
        out_len_q     <= count_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.removed_value = out_removed_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.length        = out_len_q;

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == bole_pkg::ST_FULL) |-> out_len_q == CW'(CAPACITY))
    else $error("full response with length below capacity");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == bole_pkg::ST_EMPTY) |-> out_len_q == '0)
    else $error("empty response with nonzero length");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != bole_pkg::ST_OK) |-> out_removed_q == '0)
    else $error("failed operation returned a value");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> (state_q == S_IDLE) && out_valid_q && (count_q == out_len_q))
    else $error("executed operation did not post its response");

endmodule

### hw/rtl/bole_cell.sv
// ----------------------------------------------------------------------------
// List cell
// Holds one element, compares it with the search key, shifts to or from its
// neighbors and passes the first-match and picked-value chains along.
// ----------------------------------------------------------------------------
module bole_cell #(
  parameter int unsigned VALUE_WIDTH = bole_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  bole_pkg::cell_ctrl_t     ctrl_i,
  input  logic [VALUE_WIDTH-1:0]   key_i,
  input  logic [VALUE_WIDTH-1:0]   left_i,
  input  logic [VALUE_WIDTH-1:0]   right_i,
  input  logic                     found_i,
  input  logic [VALUE_WIDTH-1:0]   pick_i,
  output logic [VALUE_WIDTH-1:0]   value_o,
  output logic                     found_o,
  output logic [VALUE_WIDTH-1:0]   pick_o
);

  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic                   match_q, match_d;
  logic                   first;
  logic                   sel;

  assign first   = match_q & ctrl_i.occupied & ~found_i;
  assign found_o = found_i | (match_q & ctrl_i.occupied);
  assign sel     = ctrl_i.pick_fixed | (ctrl_i.search & first);
  assign pick_o  = pick_i | (value_q & {VALUE_WIDTH{sel}});
  assign value_o = value_q;

  always_comb begin
    match_d = ctrl_i.capture ? (value_q == key_i) : match_q;
    priority if (ctrl_i.load) begin
      value_d = key_i;
    end else if (ctrl_i.take_left) begin
      value_d = left_i;
    end else if ((ctrl_i.shift_all | (ctrl_i.shift_found & found_o)) & ctrl_i.below_last) begin
      // Everything from the removed slot onward moves one place toward the head.
      value_d = right_i;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    match_q <= match_d;
  end

endmodule
